FILE: hdl/pfe_pkg.sv
// Shared constants, codes and control types for the polynomial feature expansion block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package pfe_pkg;

  localparam int MAX_FEATURES = 3;
  localparam int MAX_DEGREE   = 4;
  localparam int VALUE_WIDTH  = 16;

  localparam int ACC_W      = 32;  // Q23.8 term value
  localparam int FRAC_BITS  = 8;
  localparam int COL_W      = 6;
  localparam int DEG_W      = 3;
  localparam int FCOUNT_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  // command fields sized for the largest legal parameter values
  localparam int CMD_IDX_W = 3;  // up to 8 features
  localparam int CMD_POS_W = 2;  // up to degree 4

  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE        = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'b1;

  localparam logic [DEG_W-1:0]    DEGREE_RST = 3'd2;
  localparam logic [FCOUNT_W-1:0] FCOUNT_RST = 2'd3;

  localparam logic signed [ACC_W-1:0] ONE_Q8 = 32'sd256;

  typedef enum logic [1:0] {
    SRC_ONE,
    SRC_FEAT,
    SRC_ACC
  } out_src_e;

  typedef struct packed {
    logic                 store_we;
    logic [CMD_IDX_W-1:0] store_addr;
    logic [CMD_IDX_W-1:0] feat_sel;
    logic                 mul_en;
    logic [CMD_POS_W-1:0] mul_pos;
    logic                 out_load;
    out_src_e             out_src;
    logic [COL_W-1:0]     out_column;
    logic [DEG_W-1:0]     out_degree;
    logic                 out_last;
  } pfe_cmd_t;

  typedef struct packed {
    logic out_free;
  } pfe_stat_t;

endpackage

FILE: hdl/pfe_if.sv
// Valid/ready channel interfaces for feature beats in and monomial beats out.
// Depends on pfe_pkg for default widths.
interface pfe_in_if #(
  parameter int VALUE_WIDTH = pfe_pkg::VALUE_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] feature_value;

  modport source (output valid, output feature_value, input ready);
  modport sink (input valid, input feature_value, output ready);
endinterface

interface pfe_out_if;
  logic                             valid;
  logic                             ready;
  logic [pfe_pkg::COL_W-1:0]        column_index;
  logic [pfe_pkg::DEG_W-1:0]        term_degree;
  logic signed [pfe_pkg::ACC_W-1:0] term_value;
  logic                             last_of_run;

  modport source (output valid, output column_index, output term_degree, output term_value,
                  output last_of_run, input ready);
  modport sink (input valid, input column_index, input term_degree, input term_value,
                input last_of_run, output ready);
endinterface

FILE: hdl/pfe_ctrl.sv
// Sequencer: configuration registers, feature arrival count and monomial tuple walk.
// Depends on pfe_pkg; drives the datapath through pfe_cmd_t.
module pfe_ctrl #(
  parameter int MAX_FEATURES = pfe_pkg::MAX_FEATURES,
  parameter int MAX_DEGREE   = pfe_pkg::MAX_DEGREE
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pfe_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  pfe_pkg::pfe_stat_t               stat_i,
  output pfe_pkg::pfe_cmd_t                cmd_o
);

  localparam int IDX_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W = $clog2(MAX_FEATURES + 1);
  localparam int POS_W = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int DEG_W = pfe_pkg::DEG_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ONE,
    ST_MUL,
    ST_EMIT,
    ST_PASS
  } state_e;

  state_e                         state_q;
  logic [DEG_W-1:0]               degree_q;
  logic [pfe_pkg::FCOUNT_W-1:0]   fcount_q;
  logic [IDX_W-1:0]               arrival_q;
  logic [DEG_W-1:0]               deg_q;
  logic [POS_W-1:0]               pos_q;
  logic [IDX_W-1:0]               tuple_q [MAX_DEGREE];
  logic [pfe_pkg::COL_W-1:0]      col_q;

  logic [CNT_W-1:0]  n_w;
  logic [DEG_W-1:0]  dmax_w;
  logic              accept;
  logic              sample_done;
  logic              found;
  logic [POS_W-1:0]  fpos;
  logic [IDX_W-1:0]  next_val;
  logic [IDX_W-1:0]  tuple_adv [MAX_DEGREE];
  logic              last_mono;
  logic              pass_last;

  // out-of-range settings clamp into the legal range
  always_comb begin
    if (fcount_q == '0) begin
      n_w = CNT_W'(1);
    end else if (int'(fcount_q) > MAX_FEATURES) begin
      n_w = CNT_W'(MAX_FEATURES);
    end else begin
      n_w = CNT_W'(fcount_q);
    end
    if (degree_q == '0) begin
      dmax_w = DEG_W'(1);
    end else if (int'(degree_q) > MAX_DEGREE) begin
      dmax_w = DEG_W'(MAX_DEGREE);
    end else begin
      dmax_w = degree_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign sample_done = (int'(arrival_q) + 1) >= int'(n_w);
  assign pass_last   = (int'(tuple_q[0]) + 1) >= int'(n_w);

  // next nondecreasing tuple: bump the rightmost position with headroom, copy it rightwards
  always_comb begin
    found = 1'b0;
    fpos  = '0;
    for (int p = 0; p < MAX_DEGREE; p++) begin
      if (p < int'(deg_q) && (int'(tuple_q[p]) + 1) < int'(n_w)) begin
        found = 1'b1;
        fpos  = POS_W'(p);
      end
    end
    next_val = tuple_q[fpos] + 1'b1;
    for (int p = 0; p < MAX_DEGREE; p++) begin
      if (p == int'(fpos)) begin
        tuple_adv[p] = next_val;
      end else if (p > int'(fpos) && p < int'(deg_q)) begin
        tuple_adv[p] = next_val;
      end else begin
        tuple_adv[p] = tuple_q[p];
      end
    end
    last_mono = !found && (deg_q == dmax_w);
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.store_we   = accept;
    cmd_o.store_addr = pfe_pkg::CMD_IDX_W'(arrival_q);
    cmd_o.feat_sel   = pfe_pkg::CMD_IDX_W'(tuple_q[pos_q]);
    cmd_o.mul_pos    = pfe_pkg::CMD_POS_W'(pos_q);
    cmd_o.out_column = col_q;
    cmd_o.out_degree = deg_q;
    cmd_o.out_src    = pfe_pkg::SRC_ACC;
    unique case (state_q)
      ST_ONE: begin
        cmd_o.out_load   = stat_i.out_free;
        cmd_o.out_src    = pfe_pkg::SRC_ONE;
        cmd_o.out_degree = '0;
      end
      ST_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_last = last_mono;
      end
      ST_PASS: begin
        cmd_o.out_load   = stat_i.out_free;
        cmd_o.out_src    = pfe_pkg::SRC_FEAT;
        cmd_o.feat_sel   = pfe_pkg::CMD_IDX_W'(tuple_q[0]);
        cmd_o.out_degree = DEG_W'(1);
        cmd_o.out_last   = pass_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      degree_q  <= pfe_pkg::DEGREE_RST;
      fcount_q  <= pfe_pkg::FCOUNT_RST;
      arrival_q <= '0;
      deg_q     <= '0;
      pos_q     <= '0;
      tuple_q   <= '{default: '0};
      col_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          pfe_pkg::CFG_DEGREE:        degree_q <= cfg_data_i[DEG_W-1:0];
          pfe_pkg::CFG_FEATURE_COUNT: fcount_q <= cfg_data_i[pfe_pkg::FCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd_o.out_load) begin
        col_q <= col_q + 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (sample_done) begin
              arrival_q <= '0;
              col_q     <= '0;
              tuple_q   <= '{default: '0};
              pos_q     <= '0;
              if (dmax_w == DEG_W'(1)) begin
                deg_q   <= DEG_W'(1);
                state_q <= ST_PASS;
              end else begin
                deg_q   <= '0;
                state_q <= ST_ONE;
              end
            end else begin
              arrival_q <= arrival_q + 1'b1;
            end
          end
        end
        ST_ONE: begin
          if (stat_i.out_free) begin
            deg_q   <= DEG_W'(1);
            pos_q   <= '0;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if ((int'(pos_q) + 1) == int'(deg_q)) begin
            state_q <= ST_EMIT;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        ST_EMIT: begin
          if (stat_i.out_free) begin
            if (found) begin
              // prefix before fpos is unchanged, so its partial product is reused
              tuple_q <= tuple_adv;
              pos_q   <= fpos;
              state_q <= ST_MUL;
            end else if (last_mono) begin
              tuple_q <= '{default: '0};
              state_q <= ST_IDLE;
            end else begin
              deg_q   <= deg_q + 1'b1;
              tuple_q <= '{default: '0};
              pos_q   <= '0;
              state_q <= ST_MUL;
            end
          end
        end
        ST_PASS: begin
          if (stat_i.out_free) begin
            if (pass_last) begin
              tuple_q <= '{default: '0};
              state_q <= ST_IDLE;
            end else begin
              tuple_q[0] <= tuple_q[0] + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/pfe_dp.sv
// Datapath: feature store, shared Q8 multiplier with saturation, prefix products, output register.
// Depends on pfe_pkg; steered by pfe_ctrl through pfe_cmd_t.
module pfe_dp #(
  parameter int MAX_FEATURES = pfe_pkg::MAX_FEATURES,
  parameter int MAX_DEGREE   = pfe_pkg::MAX_DEGREE,
  parameter int VALUE_WIDTH  = pfe_pkg::VALUE_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  pfe_pkg::pfe_cmd_t                cmd_i,
  output pfe_pkg::pfe_stat_t               stat_o,
  input  logic signed [VALUE_WIDTH-1:0]    feature_value_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [pfe_pkg::COL_W-1:0]        column_index_o,
  output logic [pfe_pkg::DEG_W-1:0]        term_degree_o,
  output logic signed [pfe_pkg::ACC_W-1:0] term_value_o,
  output logic                             last_of_run_o
);

  localparam int IDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int POS_W  = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int ACC_W  = pfe_pkg::ACC_W;
  localparam int PROD_W = ACC_W + VALUE_WIDTH;

  logic signed [VALUE_WIDTH-1:0] store_q [MAX_FEATURES];
  logic signed [ACC_W-1:0]       partial_q [MAX_DEGREE];
  logic signed [ACC_W-1:0]       acc_q;
  logic                          out_valid_q;

  logic [POS_W-1:0]              pos;
  logic [POS_W-1:0]              prev_pos;
  logic signed [VALUE_WIDTH-1:0] feat;
  logic signed [ACC_W-1:0]       feat_ext;
  logic signed [ACC_W-1:0]       operand;
  logic signed [PROD_W-1:0]      prod_w;
  logic signed [PROD_W-1:0]      shift_w;
  logic signed [ACC_W-1:0]       sat_w;
  logic signed [ACC_W-1:0]       out_value_w;

  assign pos      = cmd_i.mul_pos[POS_W-1:0];
  assign prev_pos = POS_W'(pos - 1'b1);
  assign feat     = store_q[cmd_i.feat_sel[IDX_W-1:0]];
  assign feat_ext = ACC_W'(feat);
  assign operand  = (pos == '0) ? pfe_pkg::ONE_Q8 : partial_q[prev_pos];
  assign prod_w   = PROD_W'(operand) * PROD_W'(feat);
  // arithmetic shift rounds toward minus infinity
  assign shift_w  = prod_w >>> pfe_pkg::FRAC_BITS;

  always_comb begin
    if (&shift_w[PROD_W-1:ACC_W-1] || ~|shift_w[PROD_W-1:ACC_W-1]) begin
      sat_w = signed'(shift_w[ACC_W-1:0]);
    end else if (shift_w[PROD_W-1]) begin
      sat_w = signed'({1'b1, {(ACC_W-1){1'b0}}});
    end else begin
      sat_w = signed'({1'b0, {(ACC_W-1){1'b1}}});
    end
  end

  always_comb begin
    unique case (cmd_i.out_src)
      pfe_pkg::SRC_ONE:  out_value_w = pfe_pkg::ONE_Q8;
      pfe_pkg::SRC_FEAT: out_value_w = feat_ext;
      pfe_pkg::SRC_ACC:  out_value_w = acc_q;
      default:           out_value_w = acc_q;
    endcase
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_we) begin
      store_q[cmd_i.store_addr[IDX_W-1:0]] <= feature_value_i;
    end
    if (cmd_i.mul_en) begin
      partial_q[pos] <= sat_w;
      acc_q          <= sat_w;
    end
    if (cmd_i.out_load) begin
      column_index_o <= cmd_i.out_column;
      term_degree_o  <= cmd_i.out_degree;
      term_value_o   <= out_value_w;
      last_of_run_o  <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/polynomial_feature_expansion_core.sv
// Polynomial feature expansion, top level; joins pfe_ctrl and pfe_dp and uses pfe_pkg, pfe_if.
// Features of a sample arrive one per beat (signed Q7.8) and are taken one per cycle while the
// block is idle. The beat that completes the sample starts the expansion: the constant 1, then
// every monomial up to the configured degree in graded lexicographic order, one beat each, last
// one flagged; degree 1 passes the raw features through instead. All products go through one
// shared multiplier with Q8 rescale and 32-bit saturation. Prefix products are kept, so a
// monomial is multiplied only from the leftmost position that changed since the previous tuple
// of the same degree (every position for the first tuple of a degree). Three features at
// degree 4 give 35 beats. No new feature is taken from the completing beat until the final
// monomial sits in the output register. Configuration writes take effect at once and belong
// between samples.
module polynomial_feature_expansion_core #(
  parameter int MAX_FEATURES = pfe_pkg::MAX_FEATURES,
  parameter int MAX_DEGREE   = pfe_pkg::MAX_DEGREE,
  parameter int VALUE_WIDTH  = pfe_pkg::VALUE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pfe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  pfe_in_if.sink                         in_i,
  pfe_out_if.source                      out_o
);

  pfe_pkg::pfe_cmd_t  cmd;
  pfe_pkg::pfe_stat_t stat;

  pfe_ctrl #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_DEGREE   (MAX_DEGREE)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pfe_dp #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_DEGREE   (MAX_DEGREE),
    .VALUE_WIDTH  (VALUE_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .feature_value_i (in_i.feature_value),
    .out_ready_i     (out_o.ready),
    .out_valid_o     (out_o.valid),
    .column_index_o  (out_o.column_index),
    .term_degree_o   (out_o.term_degree),
    .term_value_o    (out_o.term_value),
    .last_of_run_o   (out_o.last_of_run)
  );

endmodule

FILE: hdl/pfe_checker.sv
// Port-level checks for polynomial_feature_expansion_core, attached by the bind at the end.
// Depends on pfe_pkg for widths and the Q8 constant one.
module pfe_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic [pfe_pkg::COL_W-1:0]        column_index_i,
  input logic [pfe_pkg::DEG_W-1:0]        term_degree_i,
  input logic signed [pfe_pkg::ACC_W-1:0] term_value_i,
  input logic                             last_of_run_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(column_index_i) &&
      $stable(term_value_i) && $stable(term_degree_i) && $stable(last_of_run_i))
    else $error("result beat changed while stalled");

  // while a non-final monomial waits, the expansion is still running
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_of_run_i |-> !in_ready_i)
    else $error("feature accepted in the middle of an expansion");

  // the degree-0 term is the constant one in the first column
  a_const_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && term_degree_i == '0 |->
      column_index_i == '0 && term_value_i == pfe_pkg::ONE_Q8 && !last_of_run_i)
    else $error("constant term malformed");

endmodule

bind polynomial_feature_expansion_core pfe_checker u_pfe_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .column_index_i (out_o.column_index),
  .term_degree_i  (out_o.term_degree),
  .term_value_i   (out_o.term_value),
  .last_of_run_i  (out_o.last_of_run)
);

FILE: sim/polynomial_feature_expansion_core_tb.sv
// Self-checking bench for polynomial_feature_expansion_core: random feature beats and register
// writes in, every monomial beat out compared against an in-bench expansion of the sample.
// Depends on pfe_pkg, the pfe_in_if / pfe_out_if channel interfaces and the RTL under hdl/.
module polynomial_feature_expansion_core_tb;
  import pfe_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int RANDOM_FEATURES = 480;
  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PRINT_CAP       = 20;

  typedef enum logic {OP_FEATURE, OP_REG_WRITE} stream_op_e;
  typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_COMB, SINK_TRICKLE} sink_style_e;

  typedef struct {
    stream_op_e                    kind;
    logic [CFG_IDX_W-1:0]          reg_idx;
    logic [CFG_DATA_W-1:0]         reg_data;
    logic signed [VALUE_WIDTH-1:0] value;
  } stream_op_t;

  typedef struct {
    logic [COL_W-1:0]        column;
    logic [DEG_W-1:0]        degree;
    logic signed [ACC_W-1:0] value;
    logic                    last;
  } term_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pfe_in_if  in_bus ();
  pfe_out_if out_bus ();

  polynomial_feature_expansion_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // stimulus stream and expected monomials
  stream_op_t stream_q[$];
  term_t      expected_terms[$];

  // mirror of the block's sample state
  logic signed [ACC_W-1:0] feature_store[MAX_FEATURES];
  int                      arrivals;
  logic [DEG_W-1:0]        degree_reg;
  logic [FCOUNT_W-1:0]     fcount_reg;

  int  mismatches;
  int  beats_in;
  int  terms_checked;
  int  samples_done;
  int  reg_writes;
  int  quiet_cycles;
  int  idle_cycles;
  logic in_fire_q;

  function automatic void push_feature(input logic signed [VALUE_WIDTH-1:0] v);
    stream_q.push_back('{kind: OP_FEATURE, reg_idx: '0, reg_data: '0, value: v});
  endfunction

  function automatic void push_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    stream_q.push_back('{kind: OP_REG_WRITE, reg_idx: idx, reg_data: data, value: '0});
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] pick_feature();
    logic signed [VALUE_WIDTH-1:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 6))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = 16'sh0000;
          3: v = 16'sh0100;
          4: v = -16'sh0100;
          5: v = 16'sh0001;
          default: v = -16'sh0001;
        endcase
      end
      1: v = VALUE_WIDTH'(int'($urandom_range(0, 1023)) - 512);
      default: v = VALUE_WIDTH'($urandom);
    endcase
    return v;
  endfunction

  // Q8 product: exact, floor shift by 8, clamp to 32 bits
  function automatic logic signed [ACC_W-1:0] q8_product(input logic signed [ACC_W-1:0] a,
                                                         input logic signed [ACC_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    p = p >>> FRAC_BITS;
    if (p > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (p < -64'sd2147483648) return 32'sh80000000;
    return p[ACC_W-1:0];
  endfunction

  function automatic void push_term(input int col, input int deg,
                                    input logic signed [ACC_W-1:0] v);
    expected_terms.push_back('{column: COL_W'(col), degree: DEG_W'(deg), value: v, last: 1'b0});
  endfunction

  // constant, then each degree's nondecreasing index tuples in lexicographic order; degree 1 is pass-through
  function automatic void expand_sample(input int n, input int dmax);
    int                      tuple[MAX_DEGREE];
    int                      col;
    int                      d;
    int                      i;
    int                      pos;
    logic signed [ACC_W-1:0] acc;
    col = 0;
    if (dmax == 1) begin
      for (i = 0; i < n; i++) begin
        push_term(col, 1, feature_store[i]);
        col++;
      end
    end else begin
      push_term(col, 0, ONE_Q8);
      col++;
      for (d = 1; d <= dmax; d++) begin
        for (i = 0; i < MAX_DEGREE; i++) tuple[i] = 0;
        pos = 0;
        while (pos >= 0) begin
          acc = ONE_Q8;
          for (i = 0; i < d; i++) acc = q8_product(acc, feature_store[tuple[i]]);
          push_term(col, d, acc);
          col++;
          pos = d - 1;
          while (pos >= 0 && tuple[pos] + 1 >= n) pos--;
          if (pos >= 0) begin
            tuple[pos]++;
            for (i = pos + 1; i < d; i++) tuple[i] = tuple[pos];
          end
        end
      end
    end
    expected_terms[expected_terms.size() - 1].last = 1'b1;
  endfunction

  function automatic void absorb_feature(input logic signed [VALUE_WIDTH-1:0] v);
    int n;
    int dmax;
    n    = (fcount_reg == 0) ? 1 : int'(fcount_reg);
    dmax = (degree_reg == 0) ? 1 : int'(degree_reg);
    if (n > MAX_FEATURES) n = MAX_FEATURES;
    if (dmax > MAX_DEGREE) dmax = MAX_DEGREE;
    if (arrivals < MAX_FEATURES) feature_store[arrivals] = v;
    // a count lowered mid-sample still completes on this beat
    if (arrivals + 1 < n) begin
      arrivals++;
    end else begin
      arrivals = 0;
      samples_done++;
      expand_sample(n, dmax);
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_term();
    term_t want;
    if (expected_terms.size() == 0) begin
      flag_mismatch($sformatf("beat with nothing pending, column %0d value %0d",
                              out_bus.column_index, out_bus.term_value));
      return;
    end
    want = expected_terms.pop_front();
    terms_checked++;
    if (out_bus.column_index !== want.column)
      flag_mismatch($sformatf("column_index %0d, want %0d", out_bus.column_index, want.column));
    if (out_bus.term_degree !== want.degree)
      flag_mismatch($sformatf("col %0d term_degree %0d, want %0d", want.column,
                              out_bus.term_degree, want.degree));
    if (out_bus.term_value !== want.value)
      flag_mismatch($sformatf("col %0d term_value %0d, want %0d", want.column,
                              out_bus.term_value, want.value));
    if (out_bus.last_of_run !== want.last)
      flag_mismatch($sformatf("col %0d last_of_run %b, want %b", want.column,
                              out_bus.last_of_run, want.last));
  endtask

  // monitor and predictor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_FEATURES; i++) feature_store[i] = '0;
      arrivals     = 0;
      degree_reg   = DEGREE_RST;
      fcount_reg   = FCOUNT_RST;
      quiet_cycles = 0;
      idle_cycles  = 0;
      in_fire_q   <= 1'b0;
    end else begin
      in_fire_q <= in_bus.valid && in_bus.ready;
      if (cfg_we) begin
        reg_writes++;
        case (cfg_index)
          CFG_DEGREE:        degree_reg = cfg_data[DEG_W-1:0];
          CFG_FEATURE_COUNT: fcount_reg = cfg_data[FCOUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready) begin
        beats_in++;
        absorb_feature(in_bus.feature_value);
      end
      if (out_bus.valid && out_bus.ready) check_term();
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet_cycles = 0;
      else if (quiet_cycles < 1000) quiet_cycles++;
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
  end

  // feature sender: bursts and gaps; register writes wait for a quiet block
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin : feeder
    logic       next_valid;
    logic       next_we;
    stream_op_t head;
    if (rst_ni) begin
      next_valid = in_bus.valid && !in_fire_q;
      next_we    = 1'b0;
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (stream_q.size() != 0) begin
          head = stream_q[0];
          if (head.kind == OP_FEATURE) begin
            void'(stream_q.pop_front());
            in_bus.feature_value <= head.value;
            next_valid = 1'b1;
            if (burst_left > 1) begin
              burst_left--;
            end else begin
              burst_left = $urandom_range(1, 16);
              gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 15);
            end
          end else if (expected_terms.size() == 0 && quiet_cycles >= SETTLE_CYCLES) begin
            void'(stream_q.pop_front());
            cfg_index <= head.reg_idx;
            cfg_data  <= head.reg_data;
            next_we    = 1'b1;
          end
        end
      end
      in_bus.valid <= next_valid;
      cfg_we       <= next_we;
    end
  end

  // monomial sink: switches between randomly chosen stall styles
  sink_style_e sink_style = SINK_OPEN;
  int          style_left = 0;

  always @(negedge clk_i) begin
    if (style_left == 0) begin
      sink_style = sink_style_e'($urandom_range(0, 3));
      style_left = $urandom_range(16, 96);
    end
    style_left--;
    case (sink_style)
      SINK_OPEN:    out_bus.ready <= 1'b1;
      SINK_COIN:    out_bus.ready <= 1'($urandom_range(0, 1));
      SINK_COMB:    out_bus.ready <= (style_left % 3) != 0;
      SINK_TRICKLE: out_bus.ready <= ($urandom_range(0, 7) == 0);
      default:      out_bus.ready <= 1'b1;
    endcase
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("[%0t] no beat for %0d cycles, %0d monomials outstanding", $realtime,
             idle_cycles, expected_terms.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int fed;
    int span;
    clk_i                = 1'b0;
    rst_ni               = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = CFG_DEGREE;
    cfg_data             = '0;
    in_bus.valid         = 1'b0;
    in_bus.feature_value = '0;
    out_bus.ready        = 1'b0;
    mismatches           = 0;
    beats_in             = 0;
    terms_checked        = 0;
    samples_done         = 0;
    reg_writes           = 0;

    // reset settings: degree 2 over three features, extremes and unit values
    push_feature(16'sh7FFF); push_feature(16'sh8000); push_feature(16'sh0000);
    push_feature(16'sh0100); push_feature(-16'sh0100); push_feature(16'sh0001);
    // full 35-term row, both saturation directions
    push_reg_write(CFG_DEGREE, 3'd4);
    push_feature(-16'sh0001); push_feature(16'sh7FFF); push_feature(16'sh8000);
    push_feature(16'sh7FFF); push_feature(16'sh7FFF); push_feature(16'sh7FFF);
    // pass-through
    push_reg_write(CFG_DEGREE, 3'd1);
    push_reg_write(CFG_FEATURE_COUNT, 3'd2);
    push_feature(-16'sh0001); push_feature(16'sh7FFF);
    // zero settings behave as one
    push_reg_write(CFG_DEGREE, 3'd0);
    push_reg_write(CFG_FEATURE_COUNT, 3'd0);
    push_feature(16'sh8000);
    // degree above range, then count dropped to 1 with two features held
    push_reg_write(CFG_DEGREE, 3'd7);
    push_reg_write(CFG_FEATURE_COUNT, 3'd3);
    push_feature(16'sh0080); push_feature(-16'sh0081);
    push_reg_write(CFG_FEATURE_COUNT, 3'd1);
    push_feature(16'sh0005);
    // count dropped to exactly the arrivals so far
    push_reg_write(CFG_DEGREE, 3'd3);
    push_reg_write(CFG_FEATURE_COUNT, 3'd3);
    push_feature(16'sh012C); push_feature(16'sh0190);
    push_reg_write(CFG_FEATURE_COUNT, 3'd2);
    push_feature(16'sh01F4);
    // upper data bit is dropped by the 2-bit count
    push_reg_write(CFG_DEGREE, 3'd2);
    push_reg_write(CFG_FEATURE_COUNT, 3'd7);
    push_feature(-16'sh4000); push_feature(16'sh3FFF); push_feature(16'sh00FF);

    fed = 0;
    while (fed < RANDOM_FEATURES) begin
      if ($urandom_range(0, 2) != 0)
        push_reg_write(CFG_DEGREE, ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 7))
                                                               : CFG_DATA_W'($urandom_range(1, 4)));
      if ($urandom_range(0, 2) != 0)
        push_reg_write(CFG_FEATURE_COUNT,
                       ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom_range(0, 7))
                                                   : CFG_DATA_W'($urandom_range(1, 3)));
      span = $urandom_range(1, 40);
      repeat (span) push_feature(pick_feature());
      fed += span;
    end

    repeat (2) @(posedge clk_i);
    #(CLK_PERIOD / 4) rst_ni = 1'b1;

    wait (stream_q.size() == 0);
    @(negedge clk_i);
    while (in_bus.valid || cfg_we || expected_terms.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("covered %0d feature beats and %0d register writes: %0d samples expanded,",
             beats_in, reg_writes, samples_done);
    $display("%0d monomial beats checked, %0d mismatches", terms_checked, mismatches);
    if (mismatches == 0 && expected_terms.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/pfe_pkg.sv
hdl/pfe_if.sv
hdl/pfe_ctrl.sv
hdl/pfe_dp.sv
hdl/polynomial_feature_expansion_core.sv
hdl/pfe_checker.sv
sim/polynomial_feature_expansion_core_tb.sv
